/* rtl/core/bdhc_pkg.sv */
package bdhc_pkg;

    localparam int unsigned NUM_BUTTONS = 4;
    localparam int unsigned NUM_KEYS    = 12;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;

    // button positions
    localparam int unsigned BTN_A = 0;
    localparam int unsigned BTN_B = 1;
    localparam int unsigned BTN_X = 2;
    localparam int unsigned BTN_Y = 3;

    // key vector bit positions
    localparam int unsigned K_MENU     = 0;
    localparam int unsigned K_MAP      = 1;
    localparam int unsigned K_FWD      = 2;
    localparam int unsigned K_BACK     = 3;
    localparam int unsigned K_STRAFE_L = 4;
    localparam int unsigned K_STRAFE_R = 5;
    localparam int unsigned K_FIRE     = 6;
    localparam int unsigned K_USE      = 7;
    localparam int unsigned K_WPN_UP   = 8;
    localparam int unsigned K_WPN_DOWN = 9;
    localparam int unsigned K_TURN_L   = 10;
    localparam int unsigned K_TURN_R   = 11;

    typedef logic [NUM_BUTTONS-1:0] t_btn_vec;
    typedef logic [NUM_KEYS-1:0]    t_key_vec;
    typedef logic [TIME_W-1:0]      t_time;

    typedef struct packed {
        logic [3:0]  raw_buttons;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  button_down;
        logic [3:0]  button_held;
        logic [11:0] key_down;
        logic [11:0] key_pressed;
        logic [11:0] key_released;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] dbnc_ms;
        logic [CFG_W-1:0] hold_ms;
    } t_cfg;

    typedef struct packed {
        logic down;
        logic held;
    } t_lane_flags;

    typedef struct packed {
        t_key_vec key_down;
        t_key_vec key_pressed;
        t_key_vec key_released;
    } t_keys;

endpackage

/* rtl/core/button_debounce_hold_chord_mapper_top.sv */
// Button debounce, hold detection and chord mapping.
//
// Input channel (i_in_valid/o_in_ready, i_in_data): one item is a sample of
// four raw button levels plus a millisecond timestamp. Output channel
// (o_out_valid/i_out_ready, o_out_data): one result item per input item, in
// order - debounced and held flags, the 12-bit key vector and its press and
// release edges against the previous vector.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): index 0
// debounce window, index 1 hold time, other indexes ignored. Always ready;
// write only while no items are in flight.
//
// Pipeline: input register -> per-button lanes and chord decode -> result
// register. An accepted item passes the input register, then the result
// register. One item per cycle sustained while i_out_ready is high; the lanes'
// subtract/compare and chord decode form the single combinational stage.
// When the receiver stalls, the result register holds, then the input
// register fills and o_in_ready drops; nothing is lost.
// Reset (synchronous, active low) clears all button state, the key vector
// and both valids, and loads a 50 ms debounce window and 500 ms hold time.
module button_debounce_hold_chord_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bdhc_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bdhc_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdhc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdhc_pkg::CFG_W-1:0]          i_cfg_data
);

    // configuration
    bdhc_pkg::t_cfg      r_cfg;

    // input stage
    logic                r_in_valid;
    bdhc_pkg::t_in_item  r_in;

    // result stage
    logic                r_out_valid;
    bdhc_pkg::t_out_item r_out;

    logic                adv;      // input stage item moves into result stage
    logic                in_fire;

    bdhc_pkg::t_lane_flags lane_flags [bdhc_pkg::NUM_BUTTONS];
    bdhc_pkg::t_btn_vec    down_vec;
    bdhc_pkg::t_btn_vec    held_vec;
    bdhc_pkg::t_keys       keys;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dbnc_ms <= bdhc_pkg::DEBOUNCE_RST;
            r_cfg.hold_ms <= bdhc_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bdhc_pkg::CFG_DEBOUNCE: r_cfg.dbnc_ms <= i_cfg_data;
                bdhc_pkg::CFG_HOLD:     r_cfg.hold_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
    end

    // one lane per button, side by side
    for (genvar g = 0; g < bdhc_pkg::NUM_BUTTONS; g++) begin : g_lane
        bdhc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_raw   (r_in.raw_buttons[g]),
            .i_now   (r_in.now_ms),
            .i_cfg   (r_cfg),
            .o_flags (lane_flags[g])
        );
        assign down_vec[g] = lane_flags[g].down;
        assign held_vec[g] = lane_flags[g].held;
    end

    bdhc_chord u_chord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_down  (down_vec),
        .i_held  (held_vec),
        .o_keys  (keys)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.button_down  <= down_vec;
            r_out.button_held  <= held_vec;
            r_out.key_down     <= keys.key_down;
            r_out.key_pressed  <= keys.key_pressed;
            r_out.key_released <= keys.key_released;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a key never both enters and leaves the key vector in one step
    a_edges_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.key_pressed & o_out_data.key_released) == '0))
        else $error("key pressed and released together");

    // pressed keys are a subset of the current key vector
    a_pressed_in_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.key_pressed & ~o_out_data.key_down) == '0))
        else $error("pressed key not in key vector");

    // input stage only blocks while holding an item that cannot move on
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // an item moved on always shows as a result next cycle
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("result lost after advance");

endmodule

/* rtl/core/bdhc_lane.sv */
module bdhc_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_raw,
    input  bdhc_pkg::t_time      i_now,
    input  bdhc_pkg::t_cfg       i_cfg,
    output bdhc_pkg::t_lane_flags o_flags
);

    logic            r_last_raw;
    logic            r_down;
    logic            r_held;
    bdhc_pkg::t_time r_prs_stamp;
    bdhc_pkg::t_time r_rel_stamp;

    logic            n_down;
    logic            n_held;
    bdhc_pkg::t_time n_prs_stamp;
    bdhc_pkg::t_time n_rel_stamp;

    bdhc_pkg::t_time since_rel;
    bdhc_pkg::t_time since_prs;
    logic            rel_ok;
    logic            prs_ok;
    logic            hold_ok;

    // wrapping elapsed time, compared unsigned
    assign since_rel = i_now - r_rel_stamp;
    assign since_prs = i_now - r_prs_stamp;
    assign rel_ok    = since_rel > bdhc_pkg::t_time'(i_cfg.dbnc_ms);
    assign prs_ok    = since_prs > bdhc_pkg::t_time'(i_cfg.dbnc_ms);
    assign hold_ok   = since_prs > bdhc_pkg::t_time'(i_cfg.hold_ms);

    always_comb begin
        n_down      = r_down;
        n_held      = r_held;
        n_prs_stamp = r_prs_stamp;
        n_rel_stamp = r_rel_stamp;
        if (i_raw && !r_last_raw) begin
            if (rel_ok) begin
                n_down      = 1'b1;
                n_prs_stamp = i_now;
                n_held      = 1'b0;
            end
        end else if (!i_raw && r_last_raw) begin
            if (prs_ok) begin
                n_down      = 1'b0;
                n_rel_stamp = i_now;
                n_held      = 1'b0;
            end
        end else if (i_raw && r_last_raw) begin
            if (hold_ok) begin
                n_held = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_down      <= 1'b0;
            r_held      <= 1'b0;
            r_prs_stamp <= '0;
            r_rel_stamp <= '0;
        end else if (i_adv) begin
            r_last_raw  <= i_raw;
            r_down      <= n_down;
            r_held      <= n_held;
            r_prs_stamp <= n_prs_stamp;
            r_rel_stamp <= n_rel_stamp;
        end
    end

    assign o_flags.down = n_down;
    assign o_flags.held = n_held;

endmodule

/* rtl/core/bdhc_chord.sv */
module bdhc_chord (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  bdhc_pkg::t_btn_vec   i_down,
    input  bdhc_pkg::t_btn_vec   i_held,
    output bdhc_pkg::t_keys      o_keys
);

    bdhc_pkg::t_key_vec r_key_vec;
    bdhc_pkg::t_key_vec n_key_vec;

    logic a, b, x, y, hx, hy;

    assign a  = i_down[bdhc_pkg::BTN_A];
    assign b  = i_down[bdhc_pkg::BTN_B];
    assign x  = i_down[bdhc_pkg::BTN_X];
    assign y  = i_down[bdhc_pkg::BTN_Y];
    assign hx = i_held[bdhc_pkg::BTN_X];
    assign hy = i_held[bdhc_pkg::BTN_Y];

    // priority chord decode; single keys only when no chord matches
    always_comb begin
        n_key_vec = '0;
        if (a && b && x && y) begin
            n_key_vec[bdhc_pkg::K_MENU] = 1'b1;
        end else if (x && y) begin
            n_key_vec[bdhc_pkg::K_MAP] = 1'b1;
        end else if (a && b) begin
            n_key_vec[bdhc_pkg::K_FWD] = 1'b1;
        end else if (a && y) begin
            n_key_vec[bdhc_pkg::K_BACK] = 1'b1;
        end else if (b && x) begin
            n_key_vec[bdhc_pkg::K_STRAFE_L] = 1'b1;
        end else if (b && y) begin
            n_key_vec[bdhc_pkg::K_STRAFE_R] = 1'b1;
        end else begin
            n_key_vec[bdhc_pkg::K_FIRE]     = a;
            n_key_vec[bdhc_pkg::K_USE]      = b;
            n_key_vec[bdhc_pkg::K_WPN_UP]   = x && !hx;
            n_key_vec[bdhc_pkg::K_WPN_DOWN] = y && !hy;
            n_key_vec[bdhc_pkg::K_TURN_L]   = hx;
            n_key_vec[bdhc_pkg::K_TURN_R]   = hy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vec <= '0;
        end else if (i_adv) begin
            r_key_vec <= n_key_vec;
        end
    end

    assign o_keys.key_down     = n_key_vec;
    assign o_keys.key_pressed  = n_key_vec & ~r_key_vec;
    assign o_keys.key_released = ~n_key_vec & r_key_vec;

endmodule
